// ===== rtl/jkb_pkg.sv =====
// ----------------------------------------------------------------------------
// jkb_pkg
// Shared constants for the joint keyframe blend pipeline: port field widths
// and the fixed normalization scale.
// ----------------------------------------------------------------------------
package jkb_pkg;

    localparam int ROT_W      = 64;
    localparam int VEC_W      = 48;
    localparam int FRAC_W     = 16;
    localparam int S_TDATA_W  = 2 * ROT_W + 4 * VEC_W + FRAC_W;
    localparam int M_TDATA_W  = ROT_W + 2 * VEC_W;
    localparam int NORM_K     = 15;

    typedef logic [S_TDATA_W-1:0] t_s_tdata;
    typedef logic [M_TDATA_W-1:0] t_m_tdata;

endpackage

// ===== rtl/joint_keyframe_blend_top.sv =====
// ----------------------------------------------------------------------------
// joint_keyframe_blend_top
// Blends one skeleton joint between two keyframes: nlerp on the rotation,
// linear blend with saturation on translation and scale.
//
// The slave channel takes one item per joint: both keys and the blend
// fraction packed in s_axis_tdata. The master channel returns the blended
// rotation, translation and scale in m_axis_tdata and the degenerate-rotation
// flag in m_axis_tuser.
// Throughput: one item per clock cycle while the receiver does not stall. The
// accept-to-output delay is set by the two normalizer passes in series, each
// a bit-per-stage square root followed by bit-per-stage dividers.
// Reset clears every valid bit in the pipeline; no item is in flight after it.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready falls; a bubble at the output lets the pipeline advance.
// ----------------------------------------------------------------------------
module joint_keyframe_blend_top #(
    parameter int COMPONENT_BITS = 16,
    parameter int FRACTION_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // key0_rotation, key0_translation, key0_scale, key1_rotation,
    // key1_translation, key1_scale, blend_fraction
    input  logic [jkb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // out_rotation, out_translation, out_scale
    output logic [jkb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // degenerate_rotation
    output logic [0:0]                   m_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready
);

    import jkb_pkg::*;

    localparam int CB  = COMPONENT_BITS;
    localparam int FB  = FRACTION_BITS;
    localparam int QF  = CB - 2;
    localparam int LN  = 2 * CB + 19;
    localparam int VL  = 2 * LN + 6;
    localparam int PW  = CB + FB + 2;
    localparam int SW  = PW + 1;
    localparam int RW  = SW - FB;
    localparam int DW  = 2 * CB + 2;
    localparam logic [4*CB-1:0] IDENT = (4*CB)'(1) << (3*CB + QF);

    logic              w_en;
    logic [VL-1:0]     r_vld;

    logic [ROT_W-1:0]  r_a_rot0;
    logic [ROT_W-1:0]  r_a_rot1;
    logic [6*CB-1:0]   r_a_lin0;
    logic [6*CB-1:0]   r_a_lin1;
    logic [FB-1:0]     r_a_t;
    logic [FB:0]       w_a_w0;

    logic signed [PW-1:0] r_l1_p0 [6];
    logic signed [PW-1:0] r_l1_p1 [6];
    logic [6*CB-1:0]   r_l2_lin;
    logic [6*CB-1:0]   w_lin_d;

    logic [4*CB-1:0]   w_u0;
    logic [4*CB-1:0]   w_u1;
    logic              w_nz0;
    logic              w_nz1;

    logic [4*CB-1:0]   r_d1_u0;
    logic [4*CB-1:0]   r_d1_u1;
    logic signed [2*CB-1:0] r_d1_pr [4];
    logic              r_d1_ok;

    logic [4*CB-1:0]   r_d2_u0;
    logic [4*CB-1:0]   r_d2_u1;
    logic              r_d2_ok;
    logic signed [DW-1:0] w_dot;

    logic [FB-1:0]     w_t_d;
    logic [FB:0]       w_w0_d;
    logic signed [PW-1:0] r_b1_p0 [4];
    logic signed [PW-1:0] r_b1_p1 [4];
    logic              r_b1_ok;

    logic [4*CB-1:0]   r_b2_r;
    logic              r_b2_ok;

    logic [4*CB-1:0]   w_u3;
    logic              w_nz3;
    logic              w_ok_d;

    logic [ROT_W-1:0]  r_f_rot;
    logic [6*CB-1:0]   r_f_lin;
    logic              r_f_deg;

    assign w_en          = !r_vld[VL-1] || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[VL-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_rot0 <= s_axis_tdata[63:0];
            r_a_lin0 <= {s_axis_tdata[112 +: 3*CB], s_axis_tdata[64 +: 3*CB]};
            r_a_rot1 <= s_axis_tdata[223:160];
            r_a_lin1 <= {s_axis_tdata[272 +: 3*CB], s_axis_tdata[224 +: 3*CB]};
            r_a_t    <= s_axis_tdata[320 +: FB];
        end
    end

    assign w_a_w0 = ((FB+1)'(1) << FB) - (FB+1)'(r_a_t);

    for (genvar v = 0; v < 6; v++) begin : g_lin
        logic signed [CB-1:0] s_a;
        logic signed [CB-1:0] s_b;
        logic signed [SW-1:0] s_sum;
        logic signed [SW-1:0] s_rnd;
        logic signed [RW-1:0] s_rs;
        logic [CB-1:0]        s_sat;

        assign s_a = r_a_lin0[v*CB +: CB];
        assign s_b = r_a_lin1[v*CB +: CB];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_l1_p0[v] <= PW'(s_a) * PW'(signed'({1'b0, w_a_w0}));
                r_l1_p1[v] <= PW'(s_b) * PW'(signed'({1'b0, r_a_t}));
            end
        end

        assign s_sum = SW'(r_l1_p0[v]) + SW'(r_l1_p1[v]);
        assign s_rnd = s_sum + (SW'(1) <<< (FB - 1));
        assign s_rs  = RW'(s_rnd >>> FB);

        always_comb begin
            if (s_rs > RW'((1 << (CB - 1)) - 1)) begin
                s_sat = CB'((1 << (CB - 1)) - 1);
            end else if (s_rs < RW'(-(1 << (CB - 1)))) begin
                s_sat = CB'(1) << (CB - 1);
            end else begin
                s_sat = s_rs[CB-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_l2_lin[v*CB +: CB] <= s_sat;
            end
        end
    end

    jkb_delay #(.W(6*CB), .DEPTH(2*LN + 2)) u_dly_lin (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_l2_lin),
        .o_q   (w_lin_d)
    );

    jkb_quat_norm #(.CB(CB)) u_norm0 (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_quat    (r_a_rot0[4*CB-1:0]),
        .o_unit    (w_u0),
        .o_nonzero (w_nz0)
    );

    jkb_quat_norm #(.CB(CB)) u_norm1 (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_quat    (r_a_rot1[4*CB-1:0]),
        .o_unit    (w_u1),
        .o_nonzero (w_nz1)
    );

    jkb_delay #(.W(2*FB + 1), .DEPTH(LN + 2)) u_dly_t (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   ({w_a_w0, r_a_t}),
        .o_q   ({w_w0_d, w_t_d})
    );

    for (genvar i = 0; i < 4; i++) begin : g_dot
        logic signed [CB-1:0] s_a;
        logic signed [CB-1:0] s_b;
        assign s_a = w_u0[i*CB +: CB];
        assign s_b = w_u1[i*CB +: CB];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d1_pr[i] <= (2*CB)'(s_a) * (2*CB)'(s_b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_u0 <= w_u0;
            r_d1_u1 <= w_u1;
            r_d1_ok <= w_nz0 && w_nz1;
        end
    end

    assign w_dot = DW'(r_d1_pr[0]) + DW'(r_d1_pr[1]) + DW'(r_d1_pr[2]) + DW'(r_d1_pr[3]);

    for (genvar i = 0; i < 4; i++) begin : g_neg
        logic signed [CB-1:0] s_b;
        assign s_b = r_d1_u1[i*CB +: CB];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d2_u1[i*CB +: CB] <= w_dot[DW-1] ? CB'(-s_b) : CB'(s_b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_u0 <= r_d1_u0;
            r_d2_ok <= r_d1_ok;
            r_b1_ok <= r_d2_ok;
            r_b2_ok <= r_b1_ok;
        end
    end

    for (genvar i = 0; i < 4; i++) begin : g_qblend
        logic signed [CB-1:0] s_a;
        logic signed [CB-1:0] s_b;
        logic signed [SW-1:0] s_sum;
        logic signed [SW-1:0] s_rnd;

        assign s_a = r_d2_u0[i*CB +: CB];
        assign s_b = r_d2_u1[i*CB +: CB];

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_b1_p0[i] <= PW'(s_a) * PW'(signed'({1'b0, w_w0_d}));
                r_b1_p1[i] <= PW'(s_b) * PW'(signed'({1'b0, w_t_d}));
            end
        end

        assign s_sum = SW'(r_b1_p0[i]) + SW'(r_b1_p1[i]);
        assign s_rnd = (s_sum + (SW'(1) <<< (FB - 1))) >>> FB;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_b2_r[i*CB +: CB] <= s_rnd[CB-1:0];
            end
        end
    end

    jkb_quat_norm #(.CB(CB)) u_norm2 (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_quat    (r_b2_r),
        .o_unit    (w_u3),
        .o_nonzero (w_nz3)
    );

    jkb_delay #(.W(1), .DEPTH(LN)) u_dly_ok (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_d   (r_b2_ok),
        .o_q   (w_ok_d)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_rot <= ROT_W'((w_ok_d && w_nz3) ? w_u3 : IDENT);
            r_f_deg <= !(w_ok_d && w_nz3);
            r_f_lin <= w_lin_d;
        end
    end

    assign m_axis_tvalid = r_vld[VL-1];
    assign m_axis_tuser  = r_f_deg;
    assign m_axis_tdata  = {VEC_W'(r_f_lin[6*CB-1:3*CB]), VEC_W'(r_f_lin[3*CB-1:0]), r_f_rot};

    logic signed [CB-1:0] w_out_w;
    assign w_out_w = m_axis_tdata[3*CB +: CB];

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_degenerate_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[ROT_W-1:0] == ROT_W'(IDENT))
        else $error("degenerate item without identity rotation");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            (w_out_w <= CB'(1 << QF)) && (w_out_w >= CB'(-(1 << QF))))
        else $error("rotation component beyond unit range");

endmodule

// ===== rtl/jkb_delay.sv =====
// ----------------------------------------------------------------------------
// jkb_delay
// Enable-gated delay line that carries side data alongside pipelined units.
// ----------------------------------------------------------------------------
module jkb_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_line [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];

endmodule

// ===== rtl/jkb_isqrt.sv =====
// ----------------------------------------------------------------------------
// jkb_isqrt
// Pipelined integer square root, one root bit resolved per register stage.
// ----------------------------------------------------------------------------
module jkb_isqrt #(
    parameter int IN_W = 64
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [IN_W-1:0]   i_rad,
    output logic [IN_W/2-1:0] o_root
);

    localparam int OUT_W = IN_W / 2;

    logic [IN_W-1:0] r_rem  [OUT_W];
    logic [IN_W-1:0] r_root [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_stage
        logic [IN_W-1:0] s_rem;
        logic [IN_W-1:0] s_root;
        logic [IN_W-1:0] s_bit;
        logic [IN_W-1:0] s_trial;

        if (k == 0) begin : g_first
            assign s_rem  = i_rad;
            assign s_root = '0;
        end else begin : g_next
            assign s_rem  = r_rem[k-1];
            assign s_root = r_root[k-1];
        end

        assign s_bit   = IN_W'(1) << (2 * (OUT_W - 1 - k));
        assign s_trial = s_root + s_bit;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (s_rem >= s_trial) begin
                    r_rem[k]  <= s_rem - s_trial;
                    r_root[k] <= (s_root >> 1) + s_bit;
                end else begin
                    r_rem[k]  <= s_rem;
                    r_root[k] <= s_root >> 1;
                end
            end
        end
    end

    assign o_root = r_root[OUT_W-1][OUT_W-1:0];

endmodule

// ===== rtl/jkb_div.sv =====
// ----------------------------------------------------------------------------
// jkb_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module jkb_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 33,
    parameter int Q_W   = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    localparam int SH_W = (DEN_W + Q_W > NUM_W) ? DEN_W + Q_W : NUM_W;

    logic [NUM_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [NUM_W-1:0] s_rem;
        logic [DEN_W-1:0] s_den;
        logic [Q_W-1:0]   s_quo;
        logic [SH_W-1:0]  s_dsh;
        logic [SH_W-1:0]  s_remx;
        logic             s_ge;

        if (k == 0) begin : g_first
            assign s_rem = i_num;
            assign s_den = i_den;
            assign s_quo = '0;
        end else begin : g_next
            assign s_rem = r_rem[k-1];
            assign s_den = r_den[k-1];
            assign s_quo = r_quo[k-1];
        end

        assign s_dsh  = SH_W'(s_den) << (Q_W - 1 - k);
        assign s_remx = SH_W'(s_rem);
        assign s_ge   = (s_remx >= s_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k] <= s_den;
                if (s_ge) begin
                    r_rem[k] <= NUM_W'(s_remx - s_dsh);
                    r_quo[k] <= s_quo | (Q_W'(1) << (Q_W - 1 - k));
                end else begin
                    r_rem[k] <= s_rem;
                    r_quo[k] <= s_quo;
                end
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

// ===== rtl/jkb_quat_norm.sv =====
// ----------------------------------------------------------------------------
// jkb_quat_norm
// Pipelined quaternion normalizer: squares, sum, square root, four dividers,
// clamp and sign restore. Zero-length input gives zero and a cleared flag.
// ----------------------------------------------------------------------------
module jkb_quat_norm #(
    parameter int CB = 16
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [4*CB-1:0] i_quat,
    output logic [4*CB-1:0] o_unit,
    output logic            o_nonzero
);

    import jkb_pkg::*;

    localparam int QF      = CB - 2;
    localparam int N_W     = 2 * CB + 1;
    localparam int SQ_IN_W = 2 * CB + 32;
    localparam int SQ_W    = SQ_IN_W / 2;
    localparam int NUM_W   = 2 * CB + 15;
    localparam int DEN_W   = SQ_W + 1;
    localparam int Q_W     = CB;

    logic [CB-1:0]     r_m1  [4];
    logic [3:0]        r_sg1;
    logic [2*CB-1:0]   r_sq1 [4];

    logic [4*CB-1:0]   r_m2;
    logic [3:0]        r_sg2;
    logic [N_W-1:0]    r_n2;
    logic              r_nz2;

    logic [SQ_W-1:0]   w_root;
    logic [4*CB-1:0]   w_m_d;
    logic [4:0]        w_flag_d;
    logic [Q_W-1:0]    w_quo [4];

    logic [4*CB-1:0]   r_unit;
    logic              r_nz;

    for (genvar i = 0; i < 4; i++) begin : g_sq
        logic signed [CB-1:0] s_c;
        logic [CB-1:0]        s_m;
        assign s_c = i_quat[i*CB +: CB];
        assign s_m = s_c[CB-1] ? CB'(-s_c) : CB'(s_c);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m1[i]  <= s_m;
                r_sg1[i] <= s_c[CB-1];
                r_sq1[i] <= (2*CB)'(s_m) * (2*CB)'(s_m);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m2  <= {r_m1[3], r_m1[2], r_m1[1], r_m1[0]};
            r_sg2 <= r_sg1;
            r_n2  <= N_W'(r_sq1[0]) + N_W'(r_sq1[1]) + N_W'(r_sq1[2]) + N_W'(r_sq1[3]);
            r_nz2 <= (r_sq1[0] != '0) || (r_sq1[1] != '0) ||
                     (r_sq1[2] != '0) || (r_sq1[3] != '0);
        end
    end

    jkb_isqrt #(.IN_W(SQ_IN_W)) u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  (SQ_IN_W'({r_n2, (2*NORM_K)'(0)})),
        .o_root (w_root)
    );

    jkb_delay #(.W(4*CB), .DEPTH(SQ_W)) u_dly_m (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   (r_m2),
        .o_q   (w_m_d)
    );

    jkb_delay #(.W(5), .DEPTH(SQ_W + Q_W)) u_dly_flag (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_d   ({r_nz2, r_sg2}),
        .o_q   (w_flag_d)
    );

    for (genvar i = 0; i < 4; i++) begin : g_div
        jkb_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(Q_W)) u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num (NUM_W'({w_m_d[i*CB +: CB], (QF+NORM_K+1)'(0)}) + NUM_W'(w_root)),
            .i_den ({w_root, 1'b0}),
            .o_quo (w_quo[i])
        );

        logic [CB-1:0] s_q;
        assign s_q = (w_quo[i] > (CB'(1) << QF)) ? (CB'(1) << QF) : w_quo[i];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_flag_d[4]) begin
                    r_unit[i*CB +: CB] <= '0;
                end else if (w_flag_d[i]) begin
                    r_unit[i*CB +: CB] <= CB'(-s_q);
                end else begin
                    r_unit[i*CB +: CB] <= s_q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_nz <= w_flag_d[4];
        end
    end

    assign o_unit    = r_unit;
    assign o_nonzero = r_nz;

endmodule

// ===== tb/sv/jkb_blend_checker.sv =====
// ----------------------------------------------------------------------------
// jkb_blend_checker
// Watches both stream channels of the joint keyframe blend block, predicts
// the blended rotation, translation, scale and degenerate flag for every
// accepted input item, and compares each output item against the oldest
// prediction. Mismatch and underflow counts go out on o_fail_count.
// ----------------------------------------------------------------------------
module jkb_blend_checker
    import jkb_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_s_tdata         i_s_tdata,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    input  t_m_tdata         i_m_tdata,
    input  logic             i_m_tuser,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int CB    = 16;
    localparam int QFRAC = CB - 2;

    typedef struct packed {
        logic [63:0] rotation;
        logic [47:0] translation;
        logic [47:0] scale;
        logic        degenerate;
    } t_joint_pose;

    t_joint_pose pose_queue[$];

    function automatic longint comp(logic [63:0] word, int i);
        return longint'($signed(word[i*CB +: CB]));
    endfunction

    function automatic longint round_shift(longint v);
        return (v + (64'sd1 <<< (FRAC_W - 1))) >>> FRAC_W;
    endfunction

    function automatic longint sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic normalize_quat(input longint c[4], output longint u[4]);
        logic [63:0] n;
        logic [63:0] s;
        logic [63:0] m;
        logic [63:0] q;
        n = 0;
        for (int i = 0; i < 4; i++) begin
            m = c[i] < 0 ? -c[i] : c[i];
            n += m * m;
        end
        for (int i = 0; i < 4; i++) u[i] = 0;
        if (n == 0) return 1'b0;
        s = int_sqrt(n << (2 * NORM_K));
        for (int i = 0; i < 4; i++) begin
            m = c[i] < 0 ? -c[i] : c[i];
            q = (2 * (m << (QFRAC + NORM_K)) + s) / (2 * s);
            if (q > (64'd1 << QFRAC)) q = 64'd1 << QFRAC;
            u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
        end
        return 1'b1;
    endfunction

    function automatic logic [47:0] blend_vec(logic [47:0] a, logic [47:0] b,
                                              longint w0, longint w1);
        logic [47:0] res;
        longint v;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            v = comp(64'(a), i) * w0 + comp(64'(b), i) * w1;
            res[i*CB +: CB] = 16'(sat16(round_shift(v)));
        end
        return res;
    endfunction

    function automatic t_joint_pose blend_joint(t_s_tdata d);
        t_joint_pose p;
        logic [63:0] rot0, rot1;
        logic [47:0] tr0, sc0, tr1, sc1;
        longint c0[4], c1[4], u0[4], u1[4], r[4], q[4];
        longint t, w0, dot;
        logic ok;
        {t, w0} = '0;
        rot0 = d[0 +: 64];
        tr0  = d[64 +: 48];
        sc0  = d[112 +: 48];
        rot1 = d[160 +: 64];
        tr1  = d[224 +: 48];
        sc1  = d[272 +: 48];
        t    = longint'(d[320 +: 16]);
        w0   = (64'sd1 << FRAC_W) - t;
        for (int i = 0; i < 4; i++) begin
            c0[i] = comp(rot0, i);
            c1[i] = comp(rot1, i);
        end
        ok = normalize_quat(c0, u0);
        ok = normalize_quat(c1, u1) && ok;
        if (ok) begin
            dot = 0;
            for (int i = 0; i < 4; i++) dot += u0[i] * u1[i];
            if (dot < 0) for (int i = 0; i < 4; i++) u1[i] = -u1[i];
            for (int i = 0; i < 4; i++) r[i] = round_shift(u0[i] * w0 + u1[i] * t);
            ok = normalize_quat(r, q);
        end
        if (!ok) begin
            q[0] = 0;
            q[1] = 0;
            q[2] = 0;
            q[3] = 64'sd1 << QFRAC;
        end
        for (int i = 0; i < 4; i++) p.rotation[i*CB +: CB] = 16'(q[i]);
        p.translation = blend_vec(tr0, tr1, w0, t);
        p.scale       = blend_vec(sc0, sc1, w0, t);
        p.degenerate  = !ok;
        return p;
    endfunction

    assign o_pending = pose_queue.size();

    always @(posedge i_clk) begin
        t_joint_pose want;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready) pose_queue.push_back(blend_joint(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (pose_queue.size() == 0) begin
                    $error("output item with no prediction waiting");
                    errs++;
                end else begin
                    want = pose_queue.pop_front();
                    if (i_m_tdata[0 +: 64] !== want.rotation) begin
                        $error("out_rotation: expected %h, got %h",
                               want.rotation, i_m_tdata[0 +: 64]);
                        errs++;
                    end
                    if (i_m_tdata[64 +: 48] !== want.translation) begin
                        $error("out_translation: expected %h, got %h",
                               want.translation, i_m_tdata[64 +: 48]);
                        errs++;
                    end
                    if (i_m_tdata[112 +: 48] !== want.scale) begin
                        $error("out_scale: expected %h, got %h",
                               want.scale, i_m_tdata[112 +: 48]);
                        errs++;
                    end
                    if (i_m_tuser !== want.degenerate) begin
                        $error("degenerate_rotation: expected %b, got %b",
                               want.degenerate, i_m_tuser);
                        errs++;
                    end
                end
            end
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

// ===== tb/sv/tb_joint_keyframe_blend_top.sv =====
// ----------------------------------------------------------------------------
// tb_joint_keyframe_blend_top
// Drives directed and random joint keyframe pairs into the blend block with
// random gaps and output stalls; the checker predicts and compares each item.
// ----------------------------------------------------------------------------
module tb_joint_keyframe_blend_top;
    import jkb_pkg::*;

    localparam int LATENCY   = 108;
    localparam int WATCHDOG  = 5000;
    localparam int N_RANDOM  = 1400;
    localparam logic [15:0] Q_ONE = 16'h4000;

    logic      i_clk;
    logic      i_rst_n;
    t_s_tdata  s_axis_tdata;
    logic      s_axis_tvalid;
    logic      s_axis_tready;
    t_m_tdata  m_axis_tdata;
    logic [0:0] m_axis_tuser;
    logic      m_axis_tvalid;
    logic      m_axis_tready;
    int        fail_count;
    int        pending;
    int        idle_cycles;

    joint_keyframe_blend_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    jkb_blend_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser[0]),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [63:0] rand_quat();
        logic [63:0] q;
        int shape;
        shape = $urandom_range(0, 9);
        q = {$urandom, $urandom};
        if (shape == 0) q = '0;
        else if (shape < 4)
            for (int i = 0; i < 4; i++) q[i*16 +: 16] = 16'($signed(q[i*16 +: 16]) >>> 2);
        else if (shape == 4)
            for (int i = 0; i < 4; i++)
                q[i*16 +: 16] = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
        else if (shape == 5)
            for (int i = 0; i < 4; i++) q[i*16 +: 16] = 16'($signed(16'($urandom)) >>> 10);
        return q;
    endfunction

    function automatic logic [47:0] rand_vec();
        logic [47:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 3) == 0)
            for (int i = 0; i < 3; i++)
                v[i*16 +: 16] = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7fff;
        return v;
    endfunction

    function automatic logic [15:0] rand_frac();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_joint(logic [63:0] r0, logic [47:0] t0, logic [47:0] s0,
                              logic [63:0] r1, logic [47:0] t1, logic [47:0] s1,
                              logic [15:0] frac);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata  <= {frac, s1, t1, r1, s0, t0, r0};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) m_axis_tready <= 1'b0;
        else if ($urandom_range(0, 3) == 0) m_axis_tready <= ($urandom_range(0, 9) < 3);
        else m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        logic [63:0] ident;
        logic [63:0] neg_ident;
        ident         = {Q_ONE, 48'h0};
        neg_ident     = {16'hc000, 48'h0};
        i_rst_n       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
        idle_cycles   = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_joint(ident, '0, '0, ident, '0, '0, 16'h0000);
        send_joint(ident, {3{16'h7fff}}, {3{16'h7fff}}, ident, {3{16'h7fff}},
                   {3{16'h7fff}}, 16'hffff);
        send_joint(ident, {3{16'h8000}}, {3{16'h8000}}, ident, {3{16'h8000}},
                   {3{16'h8000}}, 16'h8000);
        send_joint('0, 48'h0100_0200_0300, '0, ident, '1, '1, 16'h4000);
        send_joint(ident, '0, '0, '0, '0, '0, 16'h4000);
        send_joint('0, '0, '0, '0, '0, '0, 16'h1234);
        send_joint(ident, '0, '0, neg_ident, '0, '0, 16'h8000);
        send_joint(ident, '0, '0, {16'h4000, 48'h0}, '0, '0, 16'h8000);
        send_joint({16'h0, 16'h0, 16'h0, Q_ONE}, '0, '0, ident, '0, '0, 16'h8000);
        send_joint({16'h0, 16'h0, 16'h0, 16'hc000}, '0, '0, ident, '0, '0, 16'h8000);
        send_joint({4{16'h8000}}, '0, '0, {4{16'h7fff}}, '0, '0, 16'h8000);
        send_joint({4{16'h7fff}}, '1, '1, {4{16'h8000}}, '1, '1, 16'hffff);
        send_joint({16'h0, 16'h0, 16'h0, 16'h0001}, '0, '0,
                   {16'h0, 16'h0, 16'h0001, 16'h0}, '0, '0, 16'h0001);
        send_joint({4{16'hffff}}, '0, '0, {4{16'h0001}}, '0, '0, 16'h7fff);
        send_joint({16'h0, 16'h0, 16'h0, 16'h0001}, '0, '0,
                   {16'h0, 16'h0, 16'h0, 16'hffff}, '0, '0, 16'h8000);

        for (int n = 0; n < N_RANDOM; n++)
            send_joint(rand_quat(), rand_vec(), rand_vec(), rand_quat(), rand_vec(),
                       rand_vec(), rand_frac());
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/jkb_pkg.sv
rtl/jkb_delay.sv
rtl/jkb_isqrt.sv
rtl/jkb_div.sv
rtl/jkb_quat_norm.sv
rtl/joint_keyframe_blend_top.sv
tb/sv/jkb_blend_checker.sv
tb/sv/tb_joint_keyframe_blend_top.sv
